FILE: sv/positional_list_engine_core_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, skipped while reset is asserted
`define PLE_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
// Checked property, also evaluated during reset
`define PLE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define PLE_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define PLE_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

FILE: sv/ple_pkg.sv
package ple_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 16;
    localparam int DATA_W    = 32;

    // Command codes
    typedef enum logic [2:0] {
        CMD_APPEND      = 3'd0,
        CMD_INSERT      = 3'd1,
        CMD_REMOVE_LAST = 3'd2,
        CMD_REMOVE_AT   = 3'd3,
        CMD_READ        = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_FINISH = 1'b1
    } state_t;

    // Per-cell update selection
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_op_t;

    // Row-wide operation
    typedef enum logic [1:0] {
        ROW_HOLD   = 2'd0,
        ROW_INSERT = 2'd1,
        ROW_REMOVE = 2'd2
    } row_op_t;

    typedef struct packed {
        row_op_t              op;
        logic [IDX_W-1:0]     idx;
        logic [IDX_W-1:0]     sel;
        logic [WORD_BITS-1:0] value;
    } row_ctl_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } ple_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] first_word;
        logic [DATA_W-1:0] last_word;
    } ple_out_t;

endpackage

FILE: sv/ple_cell.sv
// One list slot: holds a word, loads a new one or takes a neighbor's.
module ple_cell
    import ple_pkg::*;
(
    input  logic                 clk,
    input  cell_op_t             op,
    input  logic [WORD_BITS-1:0] value,
    input  logic [WORD_BITS-1:0] left,
    input  logic [WORD_BITS-1:0] right,
    output logic [WORD_BITS-1:0] word
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // next word
    always_comb
    begin
        unique case (op)
            CELL_HOLD:  word_next = word_reg;
            CELL_LOAD:  word_next = value;
            CELL_LEFT:  word_next = left;
            CELL_RIGHT: word_next = right;
            default:    word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

FILE: sv/ple_cell_row.sv
// Row of cells: cell 0 is the head. Insert shifts toward the tail,
// remove shifts toward the head. One indexed read port.
module ple_cell_row
    import ple_pkg::*;
(
    input  logic                 clk,
    input  row_ctl_t             ctl,
    output logic [WORD_BITS-1:0] sel_word,
    output logic [WORD_BITS-1:0] head_word
);

    logic [WORD_BITS-1:0] words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_op_t             op;
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;

        if (i == 0)
        begin : g_head
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right = words[i];
        end
        else
        begin : g_mid_r
            assign right = words[i+1];
        end

        // per-cell decode of the row operation
        always_comb
        begin
            unique case (ctl.op)
                ROW_INSERT:
                begin
                    if (IDX_W'(i) == ctl.idx)
                        op = CELL_LOAD;
                    else if (IDX_W'(i) > ctl.idx)
                        op = CELL_LEFT;
                    else
                        op = CELL_HOLD;
                end
                ROW_REMOVE:
                begin
                    if (IDX_W'(i) >= ctl.idx)
                        op = CELL_RIGHT;
                    else
                        op = CELL_HOLD;
                end
                default: op = CELL_HOLD;
            endcase
        end

        ple_cell u_cell (
            .clk   (clk),
            .op    (op),
            .value (ctl.value),
            .left  (left),
            .right (right),
            .word  (words[i])
        );
    end

    assign sel_word  = words[ctl.sel];
    assign head_word = words[0];

endmodule

FILE: sv/positional_list_engine_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------------------
// command   | start / busy       | ple_in_t  (cmd, position, value)
// result    | done strobe        | ple_out_t (status, data_out, count, ...)
//
// Each command passes through S_IDLE and S_FINISH in the core: when it is
// accepted in S_IDLE, the cell row updates and the removed or read word is
// captured, and in S_FINISH the tail word is fetched through the row's single
// indexed read port. busy is high in S_FINISH, so the core takes no new command
// until it is back in S_IDLE. The result beat shows on the result port with done.
// Reset clears the count and control; cell contents are don't-care.
// The receiver cannot stall: each result beat is present for one cycle.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core
    import ple_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ple_in_t  command,
    output logic     done,
    output ple_out_t result
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     entries_reg, entries_next;
    status_t              status_reg, status_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    ple_out_t             result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic                 pop_tail;
    logic [IDX_W-1:0]     last_idx;
    logic [POS_W-1:0]     cnt_ext;
    logic                 full;
    row_ctl_t             ctl;
    logic [WORD_BITS-1:0] sel_word;
    logic [WORD_BITS-1:0] head_word;

    assign cnt_ext  = POS_W'(entries_reg);
    assign last_idx = IDX_W'(entries_reg - CNT_W'(1));
    assign full     = (entries_reg == CNT_W'(DEPTH));

    // remove that takes the tail without shifting
    assign pop_tail = (command.cmd == CMD_REMOVE_LAST) ||
                      ((command.cmd == CMD_REMOVE_AT) &&
                       (command.position >= cnt_ext - POS_W'(1)));

    // next state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   state_next = start ? S_FINISH : S_IDLE;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                accept    = start;
                done_next = 1'b0;
            end
            S_FINISH:
            begin
                busy      = 1'b1;
                accept    = 1'b0;
                done_next = 1'b1;
            end
            default:
            begin
                busy      = 1'b0;
                accept    = 1'b0;
                done_next = 1'b0;
            end
        endcase
    end

    // command decode and row control
    always_comb
    begin
        status_next  = status_reg;
        data_next    = data_reg;
        entries_next = entries_reg;
        ctl.op       = ROW_HOLD;
        ctl.idx      = entries_reg[IDX_W-1:0];
        ctl.value    = command.value[WORD_BITS-1:0];
        ctl.sel      = last_idx;

        if (accept)
        begin
            status_next = ST_OK;
            data_next   = '0;
            ctl.sel     = pop_tail ? last_idx : command.position[IDX_W-1:0];
            unique case (command.cmd)
                CMD_APPEND, CMD_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.op       = ROW_INSERT;
                        entries_next = entries_reg + CNT_W'(1);
                        if ((command.cmd == CMD_INSERT) && (command.position < cnt_ext))
                            ctl.idx = command.position[IDX_W-1:0];
                    end
                end
                CMD_REMOVE_LAST, CMD_REMOVE_AT:
                begin
                    if (entries_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        data_next    = DATA_W'(sel_word);
                        entries_next = entries_reg - CNT_W'(1);
                        if (!pop_tail)
                        begin
                            ctl.op  = ROW_REMOVE;
                            ctl.idx = command.position[IDX_W-1:0];
                        end
                    end
                end
                CMD_READ:
                begin
                    if (entries_reg == '0)
                        status_next = ST_EMPTY;
                    else if (command.position >= cnt_ext)
                        status_next = ST_RANGE;
                    else
                        data_next = DATA_W'(sel_word);
                end
                default: ;
            endcase
        end
    end

    // result assembly in S_FINISH
    always_comb
    begin
        result_next = result_reg;
        if (state_reg == S_FINISH)
        begin
            result_next.status     = status_reg;
            result_next.data_out   = data_reg;
            result_next.count      = entries_reg;
            result_next.first_word = (entries_reg != '0) ? DATA_W'(head_word) : '0;
            result_next.last_word  = (entries_reg != '0) ? DATA_W'(sel_word) : '0;
        end
    end

    ple_cell_row u_row (
        .clk       (clk),
        .ctl       (ctl),
        .sel_word  (sel_word),
        .head_word (head_word)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            entries_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            entries_reg <= entries_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PLE_ASSERT(a_count_bound, clk, rst_n, entries_reg <= CNT_W'(DEPTH), "count above depth")
    `PLE_ASSERT(a_done_follows, clk, rst_n, (start && !busy) |-> ##2 done, "missing result beat")
    `PLE_ASSERT(a_done_source, clk, rst_n, done |-> $past(state_reg == S_FINISH), "stray result beat")
    `PLE_ASSERT(a_count_stable, clk, rst_n, !(start && !busy) |=> $stable(entries_reg), "count moved without command")

endmodule

FILE: sim/positional_list_engine_core_test.sv
`timescale 1ns / 100ps

module positional_list_engine_core_test;
    import ple_pkg::*;

    // Command codes the block has no meaning for
    localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    localparam int RANDOM_ITEMS = 400;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    ple_in_t  command = '0;
    logic     done;
    ple_out_t result;

    positional_list_engine_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the list: word 0 is the head
    logic [WORD_BITS-1:0] list_words [DEPTH];
    int unsigned          list_len = 0;

    ple_in_t     command_backlog [$];
    ple_out_t    predicted_replies [$];
    int unsigned commands_queued = 0;
    int unsigned commands_taken = 0;
    int unsigned failures = 0;
    logic        beat_taken = 1'b0;
    int unsigned hold_off = 0;
    logic        steady_run = 1'b0;

    // Apply one command to the shadow list and return the reply it should give
    function automatic ple_out_t apply_list_command(ple_in_t c);
        ple_out_t             r;
        logic [WORD_BITS-1:0] w;
        int unsigned          p;
        r = '0;
        w = c.value[WORD_BITS-1:0];
        p = 32'(c.position);
        case (c.cmd)
            CMD_APPEND, CMD_INSERT:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else if (c.cmd == CMD_APPEND || p >= list_len)
                begin
                    list_words[list_len] = w;
                    list_len++;
                end
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = w;
                    list_len++;
                end
            end
            CMD_REMOVE_LAST, CMD_REMOVE_AT:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (c.cmd == CMD_REMOVE_LAST || p >= list_len - 1)
                begin
                    list_len--;
                    r.data_out = DATA_W'(list_words[list_len]);
                end
                else
                begin
                    r.data_out = DATA_W'(list_words[p]);
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.data_out = DATA_W'(list_words[p]);
            end
            default: ;
        endcase
        r.count = CNT_W'(list_len);
        if (list_len != 0)
        begin
            r.first_word = DATA_W'(list_words[0]);
            r.last_word  = DATA_W'(list_words[list_len-1]);
        end
        return r;
    endfunction

    task automatic queue_command(logic [2:0] op, int unsigned pos, logic [DATA_W-1:0] val);
        ple_in_t c;
        c.cmd      = op;
        c.position = POS_W'(pos);
        c.value    = val;
        command_backlog.push_back(c);
        commands_queued++;
    endtask

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    // Monitor: check reply beats, predict on each accepted command beat
    always @(posedge clk)
    begin : monitor
        ple_out_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (predicted_replies.size() == 0)
                    note_failure($sformatf("unexpected reply: st=%0d data=%h cnt=%0d",
                                           result.status, result.data_out, result.count));
                else
                begin
                    want = predicted_replies.pop_front();
                    if (result.status !== want.status || result.data_out !== want.data_out ||
                        result.count !== want.count || result.first_word !== want.first_word ||
                        result.last_word !== want.last_word)
                        note_failure($sformatf({"reply mismatch: want st=%0d data=%h cnt=%0d ",
                            "head=%h tail=%h, got st=%0d data=%h cnt=%0d head=%h tail=%h"},
                            want.status, want.data_out, want.count, want.first_word,
                            want.last_word, result.status, result.data_out, result.count,
                            result.first_word, result.last_word));
                end
            end
            if (start && busy === 1'b0)
            begin
                predicted_replies.push_back(apply_list_command(command));
                commands_taken++;
            end
            beat_taken <= start && busy === 1'b0;
        end
        else
            beat_taken <= 1'b0;
    end

    // Driver: hold start until taken, then a random gap (none in steady stretches) before the next beat
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !beat_taken)
            ;
        else if (hold_off > 0)
        begin
            start <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (command_backlog.size() > 0)
        begin
            command <= command_backlog.pop_front();
            start <= 1'b1;
            // occasionally switch between gapped and back-to-back stretches
            if ($urandom_range(0, 31) == 0)
                steady_run <= !steady_run;
            hold_off <= steady_run ? 0 : $urandom_range(0, 6);
        end
        else
            start <= 1'b0;
    end

    initial
    begin : stimulus
        int unsigned      useful;
        int unsigned      n;
        int unsigned      r;
        int unsigned      pos;
        logic [2:0]       op;
        logic [DATA_W-1:0] val;
        mix_t             mix;

        // Directed: empty list corners
        queue_command(CMD_READ, 0, 32'h0);
        queue_command(CMD_REMOVE_LAST, 0, 32'h0);
        queue_command(CMD_REMOVE_AT, 0, 32'h0);
        queue_command(CMD_UNDEF_LO, 0, 32'hFFFF_FFFF);
        // extremes of the word, head and middle insert, insert past count
        queue_command(CMD_APPEND, 0, 32'h0000_0000);
        queue_command(CMD_APPEND, 32'hFFFF, 32'hFFFF_FFFF);
        queue_command(CMD_INSERT, 0, 32'hA5A5_A5A5);
        queue_command(CMD_INSERT, 1, 32'h5A5A_5A5A);
        queue_command(CMD_INSERT, 32'hFFFF, 32'h1234_5678);
        // read at tail, just past the count, far past the count
        queue_command(CMD_READ, 4, 32'h0);
        queue_command(CMD_READ, 5, 32'h0);
        queue_command(CMD_READ, 32'hFFFF, 32'h0);
        // fill to capacity, then overflow both ways
        for (int k = 0; k < DEPTH - 5; k++)
            queue_command(CMD_INSERT, $urandom_range(0, 6), $urandom);
        queue_command(CMD_APPEND, 0, 32'hDEAD_BEEF);
        queue_command(CMD_INSERT, 0, 32'hDEAD_BEEF);
        queue_command(CMD_UNDEF_HI, 3, 32'h0);
        // remove head, remove clamped to tail
        queue_command(CMD_REMOVE_AT, 0, 32'h0);
        queue_command(CMD_REMOVE_AT, 32'hFFFF, 32'h0);

        // Random: stretches that fill, drain, or mix
        useful = 0;
        n = 0;
        while (useful < RANDOM_ITEMS)
        begin
            mix = mix_t'((n / 40) % 3);
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0)
                op = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
            else
            begin
                case (mix)
                    MIX_FILL:
                        op = r < 35 ? CMD_APPEND : r < 75 ? CMD_INSERT :
                             r < 85 ? CMD_REMOVE_LAST : r < 93 ? CMD_REMOVE_AT : CMD_READ;
                    MIX_DRAIN:
                        op = r < 10 ? CMD_APPEND : r < 20 ? CMD_INSERT :
                             r < 50 ? CMD_REMOVE_LAST : r < 85 ? CMD_REMOVE_AT : CMD_READ;
                    default:
                        op = r < 20 ? CMD_APPEND : r < 40 ? CMD_INSERT :
                             r < 55 ? CMD_REMOVE_LAST : r < 75 ? CMD_REMOVE_AT : CMD_READ;
                endcase
                useful++;
            end
            // mostly positions near the list, some anywhere in the field
            if ($urandom_range(0, 9) < 7)
                pos = $urandom_range(0, DEPTH + 1);
            else
                pos = $urandom_range(0, 16'hFFFF);
            case ($urandom_range(0, 9))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase
            queue_command(op, pos, val);
            n++;
        end

        // Reset, then let the driver run
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (commands_taken < commands_queued || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("[positional_list_engine_core] OK");
        else
            $display("[positional_list_engine_core] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[positional_list_engine_core] ERROR");
        $finish;
    end

endmodule
